>>> hw/rtl/catalan_surface_evaluator_defines.svh
// Assertion macros shared by the checker files of the Catalan surface evaluator.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef CATALAN_SURFACE_EVALUATOR_DEFINES_SVH
`define CATALAN_SURFACE_EVALUATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cse_pkg.sv
// Package of the Catalan surface evaluator: widths, fixed-point constants,
// CORDIC tables and shared arithmetic functions. Depends on nothing.
package cse_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int NSTG = CORDIC_ITERATIONS + 10;

  localparam int UW = 16;
  localparam int VW = 14;
  localparam int KW = 3;
  localparam int OW = 18;
  localparam int AW = 33;
  localparam int XW = 34;
  localparam int EW = 36;
  localparam int TW = 33;
  localparam int MW = 36;
  localparam int RW = 40;

  typedef enum logic [KW-1:0] {
    KIND_POS    = 3'd0,
    KIND_DU     = 3'd1,
    KIND_DV     = 3'd2,
    KIND_NORMAL = 3'd3,
    KIND_DUU    = 3'd4,
    KIND_DUV    = 3'd5,
    KIND_DVV    = 3'd6
  } kind_t;

  localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [35:0] LN2_Q30      = 36'sd744261118;
  localparam logic signed [35:0] HALF_LN2_Q30 = 36'sd372130559;
  localparam logic signed [XW-1:0] GAIN_CIRC_Q30 = 34'sd652032874;
  localparam logic signed [XW-1:0] GAIN_HYP_Q30  = 34'sd1296540104;
  localparam logic signed [RW-1:0] ONE_Q28 = 40'sd268435456;
  localparam logic signed [RW-1:0] OUT_MAX = 40'sd131071;
  localparam logic signed [RW-1:0] OUT_MIN = -40'sd131072;

  localparam logic signed [AW-1:0] ATAN_Q30 [32] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687, 33'sd33543516, 33'sd16775851, 33'sd8388437,
    33'sd4194283, 33'sd2097149, 33'sd1048576, 33'sd524288,
    33'sd262144, 33'sd131072, 33'sd65536, 33'sd32768,
    33'sd16384, 33'sd8192, 33'sd4096, 33'sd2048,
    33'sd1024, 33'sd512, 33'sd256, 33'sd128,
    33'sd64, 33'sd32, 33'sd16, 33'sd8,
    33'sd4, 33'sd2, 33'sd1, 33'sd0
  };

  localparam logic signed [AW-1:0] ATANH_Q30 [32] = '{
    33'sd0, 33'sd589812981, 33'sd274247419, 33'sd134923406,
    33'sd67196452, 33'sd33565361, 33'sd16778582, 33'sd8388779,
    33'sd4194325, 33'sd2097155, 33'sd1048576, 33'sd524288,
    33'sd262144, 33'sd131072, 33'sd65536, 33'sd32768,
    33'sd16384, 33'sd8192, 33'sd4096, 33'sd2048,
    33'sd1024, 33'sd512, 33'sd256, 33'sd128,
    33'sd64, 33'sd32, 33'sd16, 33'sd8,
    33'sd4, 33'sd2, 33'sd1, 33'sd0
  };

  // Hyperbolic shift of iteration i; shifts 4 and 13 are repeated.
  function automatic int hyp_shift(input int i);
    int s;
    logic again;
    s = 1;
    again = 1'b0;
    for (int j = 0; j < i; j++) begin
      if ((s == 4 || s == 13) && !again) begin
        again = 1'b1;
      end else begin
        again = 1'b0;
        s++;
      end
    end
    return s;
  endfunction

  // Q28 by Q28 product, rounded half up back to Q28.
  function automatic logic signed [MW-1:0] mulq(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    logic signed [2*TW-1:0] r;
    p = a * b;
    r = (p + (66'sd1 <<< 27)) >>> 28;
    return r[MW-1:0];
  endfunction

  // Q28 to Q12, rounded half up and saturated.
  function automatic logic signed [OW-1:0] to_out(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] q;
    q = (v + 40'sd32768) >>> 16;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return q[OW-1:0];
  endfunction

endpackage

>>> hw/rtl/cse_in_if.sv
// Input channel of the Catalan surface evaluator: valid, ready and (u, v).
// Depends on cse_pkg.
interface cse_in_if import cse_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [UW-1:0] param_u;
  logic signed [VW-1:0] param_v;

  modport source (output valid, output param_u, output param_v, input ready);
  modport sink (input valid, input param_u, input param_v, output ready);
endinterface

>>> hw/rtl/cse_out_if.sv
// Output channel of the Catalan surface evaluator: valid, ready and one vector.
// Depends on cse_pkg.
interface cse_out_if import cse_pkg::*; ();
  logic valid;
  logic ready;
  logic [KW-1:0] vector_kind;
  logic signed [OW-1:0] comp_x;
  logic signed [OW-1:0] comp_y;
  logic signed [OW-1:0] comp_z;
  logic last_vector;

  modport source (output valid, output vector_kind, output comp_x, output comp_y,
                  output comp_z, output last_vector, input ready);
  modport sink (input valid, input vector_kind, input comp_x, input comp_y,
                input comp_z, input last_vector, output ready);
endinterface

>>> hw/rtl/catalan_surface_evaluator.sv
// Top level of the Catalan surface evaluator: CORDIC pipeline, product stages
// and vector serializer. Depends on cse_pkg, cse_in_if and cse_out_if.
//
//   channel   direction   payload
//   params    in          param_u, param_v
//   vectors   out         vector_kind, comp_x, comp_y, comp_z, last_vector
//
// One input gives seven output transactions, one vector per cycle while the output
// channel is ready, so the output channel limits how often the block takes an input;
// the pipeline keeps taking inputs while the serializer sends the previous vectors.
// Reset clears the stage valid bits and the serializer. When the last stage holds
// an item that the serializer cannot take, the whole pipeline holds in place.
module catalan_surface_evaluator import cse_pkg::*; (
  input logic clk,
  input logic rst,
  cse_in_if.sink params,
  cse_out_if.source vectors
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int LAST = NSTG - 1;

  typedef struct packed {
    logic signed [AW-1:0] ang;
    logic neg;
  } cred_t;

  typedef struct packed {
    logic signed [AW-1:0] ang;
    logic signed [2:0] k;
  } hred_t;

  typedef struct packed {
    logic signed [TW-1:0] su;
    logic signed [TW-1:0] cu;
    logic signed [TW-1:0] sh;
    logic signed [TW-1:0] ch;
    logic signed [TW-1:0] shv;
    logic signed [TW-1:0] chv;
    logic signed [TW-1:0] shh;
    logic signed [TW-1:0] chh;
  } trig_t;

  typedef struct packed {
    logic signed [MW-1:0] fa;
    logic signed [MW-1:0] fb;
    logic signed [MW-1:0] fc;
    logic signed [MW-1:0] fd;
    logic signed [MW-1:0] fe;
    logic signed [MW-1:0] ff;
    logic signed [MW-1:0] fg;
    logic signed [MW-1:0] fh;
    logic signed [MW-1:0] fi;
    logic signed [MW-1:0] p1;
    logic signed [MW-1:0] p2;
    logic signed [TW-1:0] su;
    logic signed [TW-1:0] cu;
    logic signed [TW-1:0] sh;
    logic signed [TW-1:0] ch;
  } m1_t;

  typedef struct packed {
    logic signed [MW-1:0] fa;
    logic signed [MW-1:0] fb;
    logic signed [MW-1:0] fc;
    logic signed [MW-1:0] fd;
    logic signed [MW-1:0] fe;
    logic signed [MW-1:0] ff;
    logic signed [MW-1:0] fg;
    logic signed [MW-1:0] fh;
    logic signed [MW-1:0] fi;
    logic signed [MW-1:0] pa;
    logic signed [MW-1:0] pb;
    logic signed [MW-1:0] pc;
    logic signed [MW-1:0] pd;
    logic signed [TW-1:0] sh;
    logic signed [TW-1:0] ch;
  } m2_t;

  typedef struct packed {
    logic signed [MW-1:0] fa;
    logic signed [MW-1:0] fb;
    logic signed [MW-1:0] fc;
    logic signed [MW-1:0] fd;
    logic signed [MW-1:0] fe;
    logic signed [MW-1:0] ff;
    logic signed [MW-1:0] fg;
    logic signed [MW-1:0] fh;
    logic signed [MW-1:0] fi;
    logic signed [MW-1:0] q1;
    logic signed [MW-1:0] q2;
    logic signed [MW-1:0] q3;
    logic signed [MW-1:0] q4;
  } m3_t;

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } vec_t;

  function automatic cred_t circ_reduce(input logic signed [35:0] a);
    cred_t r;
    logic [1:0] np;
    logic [1:0] nn;
    logic signed [35:0] t;
    np = 2'(a > HALF_PI_Q30) + 2'(a > HALF_PI_Q30 + PI_Q30)
       + 2'(a > HALF_PI_Q30 + 2 * PI_Q30);
    nn = 2'(a < -HALF_PI_Q30) + 2'(a < -HALF_PI_Q30 - PI_Q30)
       + 2'(a < -HALF_PI_Q30 - 2 * PI_Q30);
    case (np)
      2'd1: t = a - PI_Q30;
      2'd2: t = a - 2 * PI_Q30;
      2'd3: t = a - 3 * PI_Q30;
      default: t = a;
    endcase
    case (nn)
      2'd1: t = t + PI_Q30;
      2'd2: t = t + 2 * PI_Q30;
      2'd3: t = t + 3 * PI_Q30;
      default: t = t;
    endcase
    r.ang = t[AW-1:0];
    r.neg = np[0] ^ nn[0];
    return r;
  endfunction

  function automatic hred_t hyp_reduce(input logic signed [35:0] a);
    hred_t r;
    logic [1:0] np;
    logic [1:0] nn;
    logic signed [35:0] t;
    np = 2'(a > HALF_LN2_Q30) + 2'(a > HALF_LN2_Q30 + LN2_Q30)
       + 2'(a > HALF_LN2_Q30 + 2 * LN2_Q30);
    nn = 2'(a < -HALF_LN2_Q30) + 2'(a < -HALF_LN2_Q30 - LN2_Q30)
       + 2'(a < -HALF_LN2_Q30 - 2 * LN2_Q30);
    case (np)
      2'd1: t = a - LN2_Q30;
      2'd2: t = a - 2 * LN2_Q30;
      2'd3: t = a - 3 * LN2_Q30;
      default: t = a;
    endcase
    case (nn)
      2'd1: t = t + LN2_Q30;
      2'd2: t = t + 2 * LN2_Q30;
      2'd3: t = t + 3 * LN2_Q30;
      default: t = t;
    endcase
    r.ang = t[AW-1:0];
    r.k = $signed({1'b0, np}) - $signed({1'b0, nn});
    return r;
  endfunction

  function automatic logic signed [TW-1:0] circ_fin(input logic signed [XW-1:0] v,
                                                    input logic neg);
    logic signed [XW:0] t;
    t = (XW+1)'(v);
    if (neg) begin
      t = -t;
    end
    t = (t + 35'sd2) >>> 2;
    return t[TW-1:0];
  endfunction

  function automatic logic signed [EW-1:0] scale_exp(input logic signed [XW:0] e,
                                                     input logic signed [3:0] sh);
    logic signed [EW-1:0] w;
    w = EW'(e);
    if (sh < 0) begin
      w = w <<< 1;
    end else if (sh != 4'sd0) begin
      w = (w + (36'sd1 <<< (sh - 4'sd1))) >>> sh;
    end
    return w;
  endfunction

  logic en;
  logic [NSTG-1:0] vld;
  logic ser_valid;
  logic ser_take;
  kind_t ser_idx;
  vec_t ser_vec [7];

  logic signed [UW-1:0] u_d [N+8];
  logic signed [VW-1:0] v_q;

  logic signed [XW-1:0] cx [N+1][2];
  logic signed [XW-1:0] cy [N+1][2];
  logic signed [AW-1:0] cz [N+1][2];
  logic cneg [N+1][2];
  logic signed [XW-1:0] hx [N+1][2];
  logic signed [XW-1:0] hy [N+1][2];
  logic signed [AW-1:0] hz [N+1][2];
  logic signed [2:0] hk [N+1][2];

  cred_t cr [2];
  hred_t hr [2];

  logic signed [TW-1:0] p1_su, p1_cu, p1_sh, p1_ch;
  logic signed [EW-1:0] p1_ep [2];
  logic signed [EW-1:0] p1_em [2];
  trig_t t2;
  trig_t t3;
  logic signed [TW-1:0] dcu;
  m1_t m1;
  m2_t m2;
  m3_t m3;
  logic signed [RW-1:0] rv [7][3];
  logic signed [RW-1:0] rv_next [7][3];
  vec_t ov [7];

  assign ser_take = !ser_valid || (vectors.ready && ser_idx == KIND_DVV);
  assign en = !vld[LAST] || ser_take;
  assign params.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], params.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_d[0] <= params.param_u;
      v_q <= params.param_v;
      for (int i = 1; i < N + 8; i++) begin
        u_d[i] <= u_d[i-1];
      end
    end
  end

  always_comb begin
    cr[0] = circ_reduce(36'(u_d[0]) <<< 18);
    cr[1] = circ_reduce(36'(u_d[0]) <<< 17);
    hr[0] = hyp_reduce(36'(v_q) <<< 18);
    hr[1] = hyp_reduce(36'(v_q) <<< 17);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        cx[0][j] <= GAIN_CIRC_Q30;
        cy[0][j] <= '0;
        cz[0][j] <= cr[j].ang;
        cneg[0][j] <= cr[j].neg;
        hx[0][j] <= GAIN_HYP_Q30;
        hy[0][j] <= '0;
        hz[0][j] <= hr[j].ang;
        hk[0][j] <= hr[j].k;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam int HS = hyp_shift(i);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 2; j++) begin
          cneg[i+1][j] <= cneg[i][j];
          hk[i+1][j] <= hk[i][j];
          if (!cz[i][j][AW-1]) begin
            cx[i+1][j] <= cx[i][j] - (cy[i][j] >>> i);
            cy[i+1][j] <= cy[i][j] + (cx[i][j] >>> i);
            cz[i+1][j] <= cz[i][j] - ATAN_Q30[i];
          end else begin
            cx[i+1][j] <= cx[i][j] + (cy[i][j] >>> i);
            cy[i+1][j] <= cy[i][j] - (cx[i][j] >>> i);
            cz[i+1][j] <= cz[i][j] + ATAN_Q30[i];
          end
          if (!hz[i][j][AW-1]) begin
            hx[i+1][j] <= hx[i][j] + (hy[i][j] >>> HS);
            hy[i+1][j] <= hy[i][j] + (hx[i][j] >>> HS);
            hz[i+1][j] <= hz[i][j] - ATANH_Q30[HS];
          end else begin
            hx[i+1][j] <= hx[i][j] - (hy[i][j] >>> HS);
            hy[i+1][j] <= hy[i][j] - (hx[i][j] >>> HS);
            hz[i+1][j] <= hz[i][j] + ATANH_Q30[HS];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_su <= circ_fin(cy[N][0], cneg[N][0]);
      p1_cu <= circ_fin(cx[N][0], cneg[N][0]);
      p1_sh <= circ_fin(cy[N][1], cneg[N][1]);
      p1_ch <= circ_fin(cx[N][1], cneg[N][1]);
      for (int j = 0; j < 2; j++) begin
        p1_ep[j] <= scale_exp((XW+1)'(hx[N][j]) + (XW+1)'(hy[N][j]),
                              4'sd2 - {hk[N][j][2], hk[N][j]});
        p1_em[j] <= scale_exp((XW+1)'(hx[N][j]) - (XW+1)'(hy[N][j]),
                              4'sd2 + {hk[N][j][2], hk[N][j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2.su <= p1_su;
      t2.cu <= p1_cu;
      t2.sh <= p1_sh;
      t2.ch <= p1_ch;
      t2.chv <= TW'(((EW+1)'(p1_ep[0]) + (EW+1)'(p1_em[0])) >>> 1);
      t2.shv <= TW'(((EW+1)'(p1_ep[0]) - (EW+1)'(p1_em[0])) >>> 1);
      t2.chh <= TW'(((EW+1)'(p1_ep[1]) + (EW+1)'(p1_em[1])) >>> 1);
      t2.shh <= TW'(((EW+1)'(p1_ep[1]) - (EW+1)'(p1_em[1])) >>> 1);
      t3 <= t2;
      dcu <= t2.chv - t2.cu;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1.fa <= mulq(t3.chv, t3.su);
      m1.fb <= mulq(t3.chv, t3.cu);
      m1.fc <= mulq(t3.sh, t3.shh);
      m1.fd <= mulq(t3.ch, t3.shh);
      m1.fe <= mulq(t3.su, t3.shv);
      m1.ff <= mulq(t3.cu, t3.shv);
      m1.fg <= mulq(t3.chh, t3.sh);
      m1.fh <= mulq(t3.shv, dcu);
      m1.fi <= mulq(t3.chh, t3.ch);
      m1.p1 <= mulq(t3.shv, t3.shh);
      m1.p2 <= mulq(t3.chv, t3.chh);
      m1.su <= t3.su;
      m1.cu <= t3.cu;
      m1.sh <= t3.sh;
      m1.ch <= t3.ch;

      m2.fa <= m1.fa;
      m2.fb <= m1.fb;
      m2.fc <= m1.fc;
      m2.fd <= m1.fd;
      m2.fe <= m1.fe;
      m2.ff <= m1.ff;
      m2.fg <= m1.fg;
      m2.fh <= m1.fh;
      m2.fi <= m1.fi;
      m2.pa <= mulq($signed(m1.p1[TW-1:0]), m1.cu);
      m2.pb <= mulq($signed(m1.p2[TW-1:0]), m1.su);
      m2.pc <= mulq($signed(m1.p2[TW-1:0]), m1.cu);
      m2.pd <= mulq($signed(m1.p1[TW-1:0]), m1.su);
      m2.sh <= m1.sh;
      m2.ch <= m1.ch;

      m3.fa <= m2.fa;
      m3.fb <= m2.fb;
      m3.fc <= m2.fc;
      m3.fd <= m2.fd;
      m3.fe <= m2.fe;
      m3.ff <= m2.ff;
      m3.fg <= m2.fg;
      m3.fh <= m2.fh;
      m3.fi <= m2.fi;
      m3.q1 <= mulq($signed(m2.pa[TW-1:0]), m2.ch);
      m3.q2 <= mulq($signed(m2.pb[TW-1:0]), m2.sh);
      m3.q3 <= mulq($signed(m2.pc[TW-1:0]), m2.sh);
      m3.q4 <= mulq($signed(m2.pd[TW-1:0]), m2.ch);
    end
  end

  always_comb begin
    logic signed [RW-1:0] a, b, c, d, e, f, g, h, i, uq;
    a = RW'(m3.fa);
    b = RW'(m3.fb);
    c = RW'(m3.fc);
    d = RW'(m3.fd);
    e = RW'(m3.fe);
    f = RW'(m3.ff);
    g = RW'(m3.fg);
    h = RW'(m3.fh);
    i = RW'(m3.fi);
    uq = RW'(u_d[N+7]) <<< 16;
    rv_next[0][0] = uq - a;
    rv_next[0][1] = ONE_Q28 - b;
    rv_next[0][2] = -(c <<< 2);
    rv_next[1][0] = ONE_Q28 - b;
    rv_next[1][1] = a;
    rv_next[1][2] = -(d <<< 1);
    rv_next[2][0] = -e;
    rv_next[2][1] = -f;
    rv_next[2][2] = -(g <<< 1);
    rv_next[3][0] = -((RW'(m3.q1) - RW'(m3.q2)) <<< 1);
    rv_next[3][1] = (RW'(m3.q4) - RW'(m3.q3) + g) <<< 1;
    rv_next[3][2] = h;
    rv_next[4][0] = a;
    rv_next[4][1] = b;
    rv_next[4][2] = c;
    rv_next[5][0] = -f;
    rv_next[5][1] = e;
    rv_next[5][2] = -i;
    rv_next[6][0] = -a;
    rv_next[6][1] = -b;
    rv_next[6][2] = -c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rv <= rv_next;
      for (int k = 0; k < 7; k++) begin
        ov[k].x <= to_out(rv[k][0]);
        ov[k].y <= to_out(rv[k][1]);
        ov[k].z <= to_out(rv[k][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx <= KIND_POS;
    end else begin
      if (ser_valid && vectors.ready) begin
        if (ser_idx == KIND_DVV) begin
          ser_valid <= 1'b0;
        end else begin
          ser_idx <= kind_t'(ser_idx + 3'd1);
        end
      end
      if (en && vld[LAST]) begin
        ser_valid <= 1'b1;
        ser_idx <= KIND_POS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAST]) begin
      ser_vec <= ov;
    end
  end

  assign vectors.valid = ser_valid;
  assign vectors.vector_kind = ser_idx;
  assign vectors.comp_x = ser_vec[ser_idx].x;
  assign vectors.comp_y = ser_vec[ser_idx].y;
  assign vectors.comp_z = ser_vec[ser_idx].z;
  assign vectors.last_vector = (ser_idx == KIND_DVV);

endmodule

>>> hw/rtl/cse_checker.sv
// Port-level checker of the Catalan surface evaluator, bound to the top level.
// Depends on cse_pkg, the channel interfaces and the assertion macro header.
`include "catalan_surface_evaluator_defines.svh"

module cse_checker import cse_pkg::*; (
  input logic clk,
  input logic rst,
  cse_in_if.sink params,
  cse_out_if.source vectors
);

  // A stalled output transaction keeps its payload.
  `CSE_ASSERT_NEXT(a_out_hold, vectors.valid && !vectors.ready, vectors.valid && $stable(vectors.vector_kind) && $stable(vectors.comp_x) && $stable(vectors.comp_y) && $stable(vectors.comp_z), "output changed while stalled")

  // The last flag marks exactly the second derivative in v.
  `CSE_ASSERT_NOW(a_last_kind, vectors.valid, vectors.last_vector == (vectors.vector_kind == KIND_DVV), "last flag does not match vector kind")

  // Within one input the vectors follow each other without a gap.
  `CSE_ASSERT_NEXT(a_kind_step, vectors.valid && vectors.ready && !vectors.last_vector, vectors.valid && vectors.vector_kind == 3'($past(vectors.vector_kind) + 3'd1), "vector sequence broken")

  // With no vector pending the input side is always open.
  `CSE_ASSERT_NOW(a_in_open, !vectors.valid, params.ready, "input blocked while output idle")

endmodule

bind catalan_surface_evaluator cse_checker u_cse_checker (
  .clk(clk),
  .rst(rst),
  .params(params),
  .vectors(vectors)
);

>>> dv/cse_checker.sv
// Checker of the Catalan surface evaluator: watches both channels, predicts the seven
// vectors of every accepted (u, v) transaction and compares them in order.
// Depends on cse_pkg, cse_in_if and cse_out_if.
module tb_cse_checker import cse_pkg::*; (
  input logic clk,
  input logic rst,
  cse_in_if params,
  cse_out_if vectors,
  output int errors,
  output int pending,
  output int checked
);

  typedef struct {
    kind_t kind;
    logic [OW-1:0] x;
    logic [OW-1:0] y;
    logic [OW-1:0] z;
    logic last;
  } surf_vec_t;

  surf_vec_t vec_queue[$];

  initial begin
    errors = 0;
    checked = 0;
  end

  assign pending = vec_queue.size();

  function automatic longint round_shift(input longint val, input int sh);
    if (sh == 0) begin
      return val;
    end
    return (val + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_shift(a * b, 28);
  endfunction

  function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
    longint a;
    longint x;
    longint y;
    longint t;
    bit neg;
    int s;
    a = ang;
    x = GAIN_CIRC_Q30;
    y = 0;
    neg = 0;
    while (a > HALF_PI_Q30) begin
      a -= PI_Q30;
      neg = !neg;
    end
    while (a < -HALF_PI_Q30) begin
      a += PI_Q30;
      neg = !neg;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      s = i % 32;
      if (a >= 0) begin
        t = x - (y >>> s);
        y = y + (x >>> s);
        a -= ATAN_Q30[s];
      end else begin
        t = x + (y >>> s);
        y = y - (x >>> s);
        a += ATAN_Q30[s];
      end
      x = t;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    sn = round_shift(y, 2);
    cs = round_shift(x, 2);
  endfunction

  function automatic longint exp_scale(input longint e, input int sh);
    if (sh < 0) begin
      return e * 2;
    end
    return round_shift(e, sh);
  endfunction

  function automatic void sinh_cosh(input longint arg, output longint sh, output longint ch);
    longint a;
    longint x;
    longint y;
    longint t;
    longint ep;
    longint em;
    int k;
    int s;
    int q;
    bit repeated;
    a = arg;
    x = GAIN_HYP_Q30;
    y = 0;
    k = 0;
    s = 1;
    repeated = 0;
    while (a > HALF_LN2_Q30) begin
      a -= LN2_Q30;
      k++;
    end
    while (a < -HALF_LN2_Q30) begin
      a += LN2_Q30;
      k--;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      q = s % 32;
      if (a >= 0) begin
        t = x + (y >>> q);
        y = y + (x >>> q);
        a -= ATANH_Q30[q];
      end else begin
        t = x - (y >>> q);
        y = y - (x >>> q);
        a += ATANH_Q30[q];
      end
      x = t;
      if ((s == 4 || s == 13) && !repeated) begin
        repeated = 1;
      end else begin
        repeated = 0;
        s++;
      end
    end
    ep = exp_scale(x + y, 2 - k);
    em = exp_scale(x - y, 2 + k);
    ch = (ep + em) >>> 1;
    sh = (ep - em) >>> 1;
  endfunction

  function automatic logic [OW-1:0] sat_q12(input longint val);
    longint q;
    q = round_shift(val, 16);
    if (q > 131071) begin
      q = 131071;
    end else if (q < -131072) begin
      q = -131072;
    end
    return q[OW-1:0];
  endfunction

  task automatic predict_surface(input logic signed [UW-1:0] pu, input logic signed [VW-1:0] pv);
    longint u;
    longint v;
    longint su;
    longint cu;
    longint sh;
    longint ch;
    longint shv;
    longint chv;
    longint shh;
    longint chh;
    longint r[7][3];
    surf_vec_t e;
    u = pu;
    v = pv;
    sin_cos(u <<< 18, su, cu);
    sin_cos(u <<< 17, sh, ch);
    sinh_cosh(v <<< 18, shv, chv);
    sinh_cosh(v <<< 17, shh, chh);
    r[0][0] = (u <<< 16) - qmul(chv, su);
    r[0][1] = (longint'(1) <<< 28) - qmul(chv, cu);
    r[0][2] = -4 * qmul(sh, shh);
    r[1][0] = (longint'(1) <<< 28) - qmul(cu, chv);
    r[1][1] = qmul(su, chv);
    r[1][2] = -2 * qmul(ch, shh);
    r[2][0] = -qmul(su, shv);
    r[2][1] = -qmul(cu, shv);
    r[2][2] = -2 * qmul(chh, sh);
    r[3][0] = -2 * (qmul(qmul(qmul(shv, shh), cu), ch)
                    - qmul(qmul(qmul(chv, chh), su), sh));
    r[3][1] = 2 * (-qmul(qmul(qmul(chv, chh), cu), sh)
                   + qmul(qmul(qmul(shv, shh), su), ch)
                   + qmul(chh, sh));
    r[3][2] = qmul(shv, chv - cu);
    r[4][0] = qmul(chv, su);
    r[4][1] = qmul(chv, cu);
    r[4][2] = qmul(sh, shh);
    r[5][0] = -qmul(shv, cu);
    r[5][1] = qmul(shv, su);
    r[5][2] = -qmul(chh, ch);
    r[6][0] = -qmul(chv, su);
    r[6][1] = -qmul(chv, cu);
    r[6][2] = -qmul(shh, sh);
    for (int k = 0; k < 7; k++) begin
      e.kind = kind_t'(k);
      e.x = sat_q12(r[k][0]);
      e.y = sat_q12(r[k][1]);
      e.z = sat_q12(r[k][2]);
      e.last = (k == 6);
      vec_queue.push_back(e);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch on vector %0d: %s got %0d expected %0d", checked, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    surf_vec_t e;
    if (!rst) begin
      if (vectors.valid && vectors.ready) begin
        if (vec_queue.size() == 0) begin
          report("unexpected transaction, kind", vectors.vector_kind, -1);
        end else begin
          e = vec_queue.pop_front();
          if (vectors.vector_kind !== e.kind) report("vector_kind", vectors.vector_kind, e.kind);
          if (vectors.comp_x !== e.x) report("comp_x", $signed(vectors.comp_x), $signed(e.x));
          if (vectors.comp_y !== e.y) report("comp_y", $signed(vectors.comp_y), $signed(e.y));
          if (vectors.comp_z !== e.z) report("comp_z", $signed(vectors.comp_z), $signed(e.z));
          if (vectors.last_vector !== e.last) report("last_vector", vectors.last_vector, e.last);
        end
        checked++;
      end
      if (params.valid && params.ready) begin
        predict_surface(params.param_u, params.param_v);
      end
    end
  end

endmodule

>>> dv/tb_catalan_surface_evaluator.sv
// Top of the Catalan surface evaluator testbench: clock, reset, stimulus, output
// back-pressure and the verdict. Depends on cse_pkg, cse_in_if, cse_out_if, tb_cse_checker.
module tb_catalan_surface_evaluator;
  import cse_pkg::*;

  localparam int NUM_RANDOM = 390;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int checked;
  int cycles;
  int sent;
  int received;
  bit burst;

  cse_in_if params ();
  cse_out_if vectors ();

  catalan_surface_evaluator dut (
    .clk(clk),
    .rst(rst),
    .params(params),
    .vectors(vectors)
  );

  tb_cse_checker chk (
    .clk(clk),
    .rst(rst),
    .params(params),
    .vectors(vectors),
    .errors(errors),
    .pending(pending),
    .checked(checked)
  );

  initial clk = 0;
  always #4 clk = ~clk;

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_catalan_surface_evaluator: errors");
      $finish;
    end
  end

  task automatic send_item(input logic signed [UW-1:0] u, input logic signed [VW-1:0] v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      params.valid = 0;
      repeat (gap) @(negedge clk);
    end
    params.valid = 1;
    params.param_u = u;
    params.param_v = v;
    do begin
      @(posedge clk);
    end while (!params.ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    logic signed [UW-1:0] dir_u[12];
    logic signed [VW-1:0] dir_v[12];
    logic signed [UW-1:0] u;
    logic signed [VW-1:0] v;
    dir_u = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767, 16'sh8000, 16'sd6434,
              -16'sd6434, 16'sd12868, 16'sd1, -16'sd1, 16'sd19302, 16'sd3217};
    dir_v = '{14'sd0, 14'sd5734, -14'sd5734, 14'sd8191, 14'sh2000, 14'sd1,
              -14'sd1, 14'sd2839, -14'sd1420, 14'sd4096, 14'sd8191, 14'sh2000};
    rst = 1;
    burst = 0;
    sent = 0;
    params.valid = 0;
    params.param_u = 0;
    params.param_v = 0;
    repeat (4) @(negedge clk);
    rst = 0;
    for (int i = 0; i < 12; i++) begin
      send_item(dir_u[i], dir_v[i]);
    end
    for (int i = 0; i < 8; i++) begin
      send_item(dir_u[i + 3], dir_v[11 - i]);
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      burst = (i >= 150 && i < 200);
      if ($urandom_range(0, 9) == 0) begin
        u = UW'($urandom());
        v = VW'($urandom());
      end else begin
        u = UW'($urandom_range(0, 51472) - 25736);
        v = VW'($urandom_range(0, 11468) - 5734);
      end
      send_item(u, v);
    end
    params.valid = 0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("%0d parameter pairs sent, %0d vectors checked, including range edges,",
             sent, checked);
    $display("out-of-range codes, back-to-back bursts and a long output stall.");
    if (errors == 0 && pending == 0) begin
      $display("tb_catalan_surface_evaluator: clean");
    end else begin
      $display("tb_catalan_surface_evaluator: errors");
    end
    $finish;
  end

  initial begin
    int hold;
    vectors.ready = 0;
    received = 0;
    hold = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        vectors.ready = 0;
        hold--;
      end else begin
        vectors.ready = 1;
      end
      @(posedge clk);
      if (vectors.valid && vectors.ready) begin
        received++;
        hold = burst ? 0 : $urandom_range(0, 9);
        if (received == 300) begin
          hold = 400;
        end
      end
    end
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cse_pkg.sv
hw/rtl/cse_in_if.sv
hw/rtl/cse_out_if.sv
hw/rtl/catalan_surface_evaluator.sv
hw/rtl/cse_checker.sv
dv/cse_checker.sv
dv/tb_catalan_surface_evaluator.sv
